// ----- sv/multi_button_debouncer_assert.svh -----
// Assertion macros used by the multi_button_debouncer module
`ifndef MULTI_BUTTON_DEBOUNCER_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dbc_pkg.sv -----
// Package: constants and types for the multi-button debouncer
package dbc_pkg;

  localparam int unsigned Channels      = 9;
  localparam int unsigned ChanW         = 4;
  localparam int unsigned CountW        = 8;
  localparam logic [CountW-1:0] CountMax      = '1;
  localparam logic [CountW-1:0] DebounceReset = 8'd20;

  typedef logic [Channels-1:0] chan_vec_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [ChanW-1:0]    chan_idx_t;

  // Result of one scan tick: which channels changed and their new state
  typedef struct packed {
    chan_vec_t mask;
    chan_vec_t pressed;
  } dbc_events_t;

endpackage

// ----- sv/dbc_tick_if.sv -----
// Interface: scan tick channel carrying raw pin levels
interface dbc_tick_if;
  import dbc_pkg::*;

  logic      valid;
  logic      ready;
  chan_vec_t pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

// ----- sv/dbc_event_if.sv -----
// Interface: debounced change event channel
interface dbc_event_if;
  import dbc_pkg::*;

  logic      valid;
  logic      ready;
  chan_idx_t channel;
  logic      pressed;
  logic      last;

  modport source (output valid, output channel, output pressed, output last, input ready);
  modport sink   (input valid, input channel, input pressed, input last, output ready);
endinterface

// ----- sv/dbc_core.sv -----
// Per-channel debounce state and change detection for one scan tick
module dbc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  dbc_pkg::chan_vec_t   pin_levels_i,
  input  dbc_pkg::count_t      debounce_i,
  output dbc_pkg::dbc_events_t events_o
);
  import dbc_pkg::*;

  logic      primed_q;
  chan_vec_t raw_q, raw_d;
  chan_vec_t stable_q, stable_d;
  count_t    cnt_q [Channels];
  count_t    cnt_d [Channels];
  chan_vec_t press;

  assign press = ~pin_levels_i;

  always_comb begin
    raw_d    = press;
    stable_d = stable_q;
    events_o = '0;
    for (int i = 0; i < Channels; i++) begin
      if (!primed_q) begin
        cnt_d[i]    = '0;
        stable_d[i] = press[i];
      end else begin
        if (press[i] != raw_q[i]) begin
          cnt_d[i] = '0;
        end else if (cnt_q[i] != CountMax) begin
          cnt_d[i] = cnt_q[i] + count_t'(1);
        end else begin
          cnt_d[i] = cnt_q[i];
        end
        if (press[i] != stable_q[i] && cnt_d[i] >= debounce_i) begin
          stable_d[i]      = press[i];
          events_o.mask[i] = 1'b1;
        end
      end
    end
    events_o.pressed = press;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      raw_q    <= '0;
      stable_q <= '0;
      for (int i = 0; i < Channels; i++) cnt_q[i] <= '0;
    end else if (tick_i) begin
      primed_q <= 1'b1;
      raw_q    <= raw_d;
      stable_q <= stable_d;
      for (int i = 0; i < Channels; i++) cnt_q[i] <= cnt_d[i];
    end
  end

endmodule

// ----- sv/multi_button_debouncer.sv -----
// Multi-button debouncer: a scan tick updates all channels in the cycle it is accepted.
// The events of an accepted tick are held in a pending mask register, then passed into the output register.
// Throughput: one tick per cycle while ticks cause at most one event and the output is not stalled; a tick
// with several events holds the input until its events are handed to the output register, one per unstalled cycle.
// Reset: all channel state cleared, debounce setting 20; the first tick only primes state.
`include "multi_button_debouncer_assert.svh"

module multi_button_debouncer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  dbc_pkg::count_t      cfg_wdata_i,
  dbc_tick_if.sink             in_i,
  dbc_event_if.source          out_o
);
  import dbc_pkg::*;

  count_t      debounce_q;
  dbc_events_t events;
  logic        in_fire;

  chan_vec_t   mask_q, mask_d, mask_rest;
  chan_vec_t   press_q;
  logic        out_load;
  chan_idx_t   low_idx;

  logic        out_valid_q;
  chan_idx_t   chan_q;
  logic        pressed_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  dbc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (in_fire),
    .pin_levels_i (in_i.pin_levels),
    .debounce_i   (debounce_q),
    .events_o     (events)
  );

  // lowest pending channel goes first
  always_comb begin
    low_idx = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (mask_q[i]) low_idx = ChanW'(i);
    end
  end

  assign mask_rest = mask_q & (mask_q - chan_vec_t'(1));
  assign out_load  = (mask_q != '0) && (!out_valid_q || out_o.ready);
  // a new tick may enter once the pending events of the previous one are all handed off
  assign in_i.ready = (mask_q == '0) || (out_load && (mask_rest == '0));
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    mask_d = mask_q;
    if (out_load) mask_d = mask_rest;
    if (in_fire)  mask_d = events.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) press_q <= events.pressed;
    if (out_load) begin
      chan_q    <= low_idx;
      pressed_q <= press_q[low_idx];
      last_q    <= (mask_rest == '0);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.channel = chan_q;
  assign out_o.pressed = pressed_q;
  assign out_o.last    = last_q;

  `DBC_ASSERT_IMPL(a_fire_drained, clk_i, rst_ni, in_fire, (mask_q == '0) || $onehot(mask_q), "tick accepted with events pending")
  `DBC_ASSERT_NEXT(a_events_loaded, clk_i, rst_ni, in_fire && (events.mask != '0), mask_q != '0, "events of tick lost")
  `DBC_ASSERT_IMPL(a_not_last_pending, clk_i, rst_ni, out_valid_q && !last_q, mask_q != '0, "non-final event with nothing pending")

endmodule

// ----- bench/dbc_change_checker.sv -----
// Checker: predicts debounced change items from accepted scan ticks and compares them
`timescale 1ns / 1ps

module dbc_change_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  dbc_pkg::count_t cfg_wdata_i,
  dbc_tick_if             tick_mon,
  dbc_event_if            event_mon,
  output int              fail_count_o,
  output int              pending_o
);
  import dbc_pkg::*;

  localparam int MaxReported = 10;

  typedef struct packed {
    chan_idx_t channel;
    logic      pressed;
    logic      last;
  } dbc_change_t;

  dbc_change_t expected_changes[$];

  chan_vec_t raw_q;
  chan_vec_t stable_q;
  count_t    elapsed_q [Channels];
  logic      primed_q;
  count_t    debounce_q;
  int        mismatch_count;

  task automatic predict_tick(input chan_vec_t levels);
    chan_vec_t now_pressed;
    chan_vec_t fire;
    now_pressed = ~levels;
    fire        = '0;
    if (!primed_q) begin
      // first tick only adopts the levels
      raw_q    = now_pressed;
      stable_q = now_pressed;
      for (int i = 0; i < Channels; i++) elapsed_q[i] = '0;
      primed_q = 1'b1;
    end else begin
      for (int i = 0; i < Channels; i++) begin
        if (now_pressed[i] != raw_q[i]) begin
          raw_q[i]     = now_pressed[i];
          elapsed_q[i] = '0;
        end else if (elapsed_q[i] != CountMax) begin
          elapsed_q[i] = elapsed_q[i] + 1'b1;
        end
        if (now_pressed[i] != stable_q[i] && elapsed_q[i] >= debounce_q) begin
          stable_q[i] = now_pressed[i];
          fire[i]     = 1'b1;
        end
      end
      for (int i = 0; i < Channels; i++) begin
        if (fire[i]) begin
          expected_changes.push_back('{channel: chan_idx_t'(i),
                                       pressed: now_pressed[i],
                                       last:    ((fire >> (i + 1)) == '0)});
        end
      end
    end
  endtask

  task automatic check_change();
    dbc_change_t want;
    if (expected_changes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReported)
        $display("%0t: unexpected item channel=%0d pressed=%0b last=%0b", $realtime,
                 event_mon.channel, event_mon.pressed, event_mon.last);
    end else begin
      want = expected_changes.pop_front();
      if (event_mon.channel !== want.channel || event_mon.pressed !== want.pressed ||
          event_mon.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("%0t: mismatch exp channel=%0d pressed=%0b last=%0b, got channel=%0d pressed=%0b last=%0b",
                   $realtime, want.channel, want.pressed, want.last,
                   event_mon.channel, event_mon.pressed, event_mon.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_changes.delete();
      raw_q    = '0;
      stable_q = '0;
      for (int i = 0; i < Channels; i++) elapsed_q[i] = '0;
      primed_q       = 1'b0;
      debounce_q     = DebounceReset;
      mismatch_count = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
    end else begin
      // results leaving now belong to earlier ticks, so check before predicting
      if (event_mon.valid && event_mon.ready) check_change();
      if (cfg_we_i) debounce_q = cfg_wdata_i;
      if (tick_mon.valid && tick_mon.ready) predict_tick(tick_mon.pin_levels);
      fail_count_o <= mismatch_count;
      pending_o    <= expected_changes.size();
    end
  end

endmodule

// ----- bench/tb_multi_button_debouncer.sv -----
// Testbench top: clock, reset, scan tick and config stimulus, event backpressure, verdict
`timescale 1ns / 1ps

module tb_multi_button_debouncer;
  import dbc_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 8;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;
  int     fail_count;
  int     pending;
  int     cycle_cnt = 0;
  bit     no_gaps;
  chan_vec_t cur_levels;

  dbc_tick_if  tick_if ();
  dbc_event_if event_if ();

  multi_button_debouncer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (tick_if),
    .out_o       (event_if)
  );

  dbc_change_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .tick_mon     (tick_if),
    .event_mon    (event_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_tick(input chan_vec_t lv);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_if.valid      <= 1'b1;
    tick_if.pin_levels <= lv;
    do @(posedge clk); while (!tick_if.ready);
    @(negedge clk);
  endtask

  task automatic hold_levels(input chan_vec_t lv, input int ticks);
    repeat (ticks) send_tick(lv);
  endtask

  task automatic wait_drained();
    tick_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_debounce(input count_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int setting, input int budget);
    int sent;
    int r;
    int hold;
    chan_vec_t flips;
    wait_drained();
    write_debounce(count_t'(setting));
    no_gaps = ($urandom_range(0, 3) == 0);
    sent    = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        // well-formed press/release: flip a few pins and hold them
        flips = chan_vec_t'($urandom) & chan_vec_t'($urandom);
        if (r < 10) flips = chan_vec_t'($urandom);
        cur_levels ^= flips;
        if ($urandom_range(0, 2) != 0) hold = setting + $urandom_range(0, 3);
        else hold = $urandom_range(1, setting + 1);
        hold_levels(cur_levels, hold);
        sent += hold;
      end else if (r < 93) begin
        // contact bounce: short glitch, then back to the held pattern
        hold = $urandom_range(1, 2);
        hold_levels(cur_levels ^ chan_vec_t'($urandom), hold);
        sent += hold;
      end else begin
        cur_levels = chan_vec_t'($urandom_range(0, 511));
        send_tick(cur_levels);
        sent += 1;
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // event sink: random stalls with occasional long ready stretches
  initial begin : event_sink
    int run;
    int gap;
    event_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
      event_if.ready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        event_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    tick_if.valid      = 1'b0;
    tick_if.pin_levels = '0;
    no_gaps            = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // priming tick at the reset setting, then a raw change that must not pass
    send_tick(9'h1FF);
    send_tick(9'h000);

    // zero debounce: changes pass on the tick they are seen
    wait_drained();
    write_debounce(count_t'(0));
    send_tick(9'h000);
    send_tick(9'h1FF);
    send_tick(9'h0AA);
    send_tick(9'h155);
    send_tick(9'h155);
    send_tick(9'h0FF);
    send_tick(9'h100);

    // one-tick debounce with a bounce back before acceptance
    wait_drained();
    write_debounce(count_t'(1));
    send_tick(9'h000);
    send_tick(9'h000);
    send_tick(9'h1FF);
    send_tick(9'h000);
    send_tick(9'h000);
    send_tick(9'h1FE);
    send_tick(9'h1FE);
    send_tick(9'h1FF);
    send_tick(9'h1FF);
    cur_levels = 9'h1FF;

    run_phase(0, 25);
    run_phase(1, 25);
    run_phase(2, 25);
    run_phase(3, 25);
    run_phase($urandom_range(4, 8), 30);
    run_phase(20, 40);
    run_phase($urandom_range(0, 3), 20);
    // top setting: only a counter at its ceiling lets a change through
    run_phase(255, 200);

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
